[rtl/core/wav_header_parser_defines.svh]
// Assertion macros shared by the wav_header_parser RTL.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef WAV_HEADER_PARSER_DEFINES_SVH
`define WAV_HEADER_PARSER_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked check, masked while reset is asserted
`define WAVHP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define WAVHP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WAVHP_ASSERT(lbl, clk, rst_n, prop, msg)
`define WAVHP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/wavhp_pkg.sv]
// Shared types, status codes and chunk identifiers for wav_header_parser.
// No dependencies.
`default_nettype none

package wavhp_pkg;

    // Result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_RIFF    = 3'd1;
    localparam logic [2:0] ST_NO_WAVE    = 3'd2;
    localparam logic [2:0] ST_NO_FMT     = 3'd3;
    localparam logic [2:0] ST_NOT_PCM    = 3'd4;
    localparam logic [2:0] ST_TRUNC      = 3'd5;
    localparam logic [2:0] ST_NO_DATA    = 3'd6;
    localparam logic [2:0] ST_ZERO_FRAME = 3'd7;

    // Chunk identifiers, first file byte in the top byte
    localparam logic [31:0] ID_RIFF = 32'h5249_4646;
    localparam logic [31:0] ID_WAVE = 32'h5741_5645;
    localparam logic [31:0] ID_FMT  = 32'h666D_7420;
    localparam logic [31:0] ID_DATA = 32'h6461_7461;

    // Standard fmt chunk length
    localparam logic [31:0] FMT_STD_LEN = 32'd16;

    // Parser phase, one-hot
    typedef enum logic [13:0] {
        PH_RIFF      = 14'b00000000000001,
        PH_RIFFSIZE  = 14'b00000000000010,
        PH_WAVE      = 14'b00000000000100,
        PH_FMT       = 14'b00000000001000,
        PH_FMTSIZE   = 14'b00000000010000,
        PH_FORMAT    = 14'b00000000100000,
        PH_CHANS     = 14'b00000001000000,
        PH_RATE      = 14'b00000010000000,
        PH_BYTERATE  = 14'b00000100000000,
        PH_ALIGN     = 14'b00001000000000,
        PH_BITS      = 14'b00010000000000,
        PH_SKIP      = 14'b00100000000000,
        PH_CHUNKID   = 14'b01000000000000,
        PH_CHUNKSIZE = 14'b10000000000000
    } phase_t;

    // One pending result, handed from the front end to the back end
    typedef struct packed {
        logic [2:0]  status;
        logic        divide;    // ok result: frame count still to compute
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [31:0] size;      // data chunk size
        logic [31:0] offset;    // first audio byte
    } job_t;

    // Queue handshake between front end and back end
    typedef struct packed {
        logic push;
        logic full;
        logic pop;
        logic empty;
    } q_ctl_t;

    // Expected identifier byte k of the chunk id for this phase
    function automatic logic [7:0] id_byte(input phase_t ph, input logic [1:0] k);
        logic [31:0] w;
        case (ph)
            PH_RIFF: w = ID_RIFF;
            PH_WAVE: w = ID_WAVE;
            PH_FMT:  w = ID_FMT;
            default: w = ID_DATA;
        endcase
        return w[{~k, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

[rtl/core/wavhp_queue.sv]
// Two-entry result queue between the wav_header_parser front and back ends.
// Depends on wavhp_pkg and wav_header_parser_defines.svh.
`default_nettype none
`include "wav_header_parser_defines.svh"

module wavhp_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire wavhp_pkg::job_t push_job,
    input  wire logic          pop,
    output wavhp_pkg::job_t    pop_job,
    output logic               full,
    output logic               empty
);

    wavhp_pkg::job_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_job = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `WAVHP_ASSERT(a_q_count_range, clk, rst_n, count_reg <= 2'd2, "queue count out of range")
    `WAVHP_ASSERT(a_q_no_overflow, clk, rst_n, push |-> !full, "push into full queue")
    `WAVHP_ASSERT(a_q_no_underflow, clk, rst_n, pop |-> !empty, "pop from empty queue")

endmodule

`default_nettype wire

[rtl/core/wavhp_front.sv]
// Byte-level header parser: walks the RIFF/WAVE header and queues one result.
// Depends on wavhp_pkg.
`default_nettype none

module wavhp_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_take,   // input word accepted this cycle
    input  wire logic [7:0]    in_byte,
    input  wire logic          first_byte,
    input  wire logic          last_byte,
    output logic               push,
    output wavhp_pkg::job_t    job
);

    wavhp_pkg::phase_t phase_reg, phase_next, cur_phase;
    logic [1:0]  k_reg, k_next, cur_k;
    logic [31:0] field_reg, field_next, cur_field;
    logic [31:0] fmt_len_reg, fmt_len_next, cur_fmt_len;
    logic [31:0] skip_reg, skip_next, cur_skip;
    logic [31:0] pos_reg, pos_next, cur_pos;
    logic [15:0] chans_reg, chans_next, cur_chans;
    logic [31:0] rate_reg, rate_next, cur_rate;
    logic [15:0] bits_reg, bits_next, cur_bits;
    logic        match_reg, match_next, cur_match;
    logic        done_reg, done_next, cur_done;

    logic        emit;
    logic [2:0]  emit_status;
    logic        emit_divide;
    logic [31:0] emit_size;
    logic [31:0] emit_offset;
    logic        match_new;
    logic [31:0] field_val;
    logic [31:0] skip_dec;
    logic [31:0] padded;
    logic        field_end;

    // Round an odd skip count up to cover the pad byte, saturating
    function automatic logic [31:0] pad_skip(input logic [31:0] n);
        if (n[0] && (n != 32'hFFFF_FFFF))
        begin
            return n + 32'd1;
        end
        return n;
    endfunction

    // A word flagged first_byte sees the reset state
    always_comb
    begin
        cur_phase   = first_byte ? wavhp_pkg::PH_RIFF : phase_reg;
        cur_k       = first_byte ? 2'd0  : k_reg;
        cur_field   = first_byte ? 32'd0 : field_reg;
        cur_fmt_len = first_byte ? 32'd0 : fmt_len_reg;
        cur_skip    = first_byte ? 32'd0 : skip_reg;
        cur_pos     = first_byte ? 32'd0 : pos_reg;
        cur_chans   = first_byte ? 16'd0 : chans_reg;
        cur_rate    = first_byte ? 32'd0 : rate_reg;
        cur_bits    = first_byte ? 16'd0 : bits_reg;
        cur_match   = first_byte ? 1'b0  : match_reg;
        cur_done    = first_byte ? 1'b0  : done_reg;
    end

    // Per-word parse step
    always_comb
    begin
        phase_next   = cur_phase;
        k_next       = cur_k;
        field_next   = cur_field;
        fmt_len_next = cur_fmt_len;
        skip_next    = cur_skip;
        pos_next     = cur_pos;
        chans_next   = cur_chans;
        rate_next    = cur_rate;
        bits_next    = cur_bits;
        match_next   = cur_match;
        done_next    = cur_done;
        emit         = 1'b0;
        emit_status  = wavhp_pkg::ST_OK;
        emit_divide  = 1'b0;
        emit_size    = 32'd0;
        emit_offset  = 32'd0;

        match_new = ((cur_k == 2'd0) || cur_match)
                    && (in_byte == wavhp_pkg::id_byte(cur_phase, cur_k));
        field_val = ((cur_k == 2'd0) ? 32'd0 : cur_field)
                    | ({24'd0, in_byte} << {cur_k, 3'b000});
        skip_dec  = cur_skip - {31'd0, (cur_skip != 32'd0)};
        padded    = pad_skip(field_val);
        field_end = (cur_phase inside {wavhp_pkg::PH_FORMAT, wavhp_pkg::PH_CHANS,
                                       wavhp_pkg::PH_ALIGN, wavhp_pkg::PH_BITS})
                    ? (cur_k == 2'd1) : (cur_k == 2'd3);

        if (!cur_done)
        begin
            pos_next = cur_pos + 32'd1;

            if (cur_phase inside {wavhp_pkg::PH_RIFF, wavhp_pkg::PH_WAVE,
                                  wavhp_pkg::PH_FMT, wavhp_pkg::PH_CHUNKID})
            begin
                // Identifier bytes, checked once all four are in
                match_next = match_new;
                if (cur_k != 2'd3)
                begin
                    k_next = cur_k + 2'd1;
                end
                else
                begin
                    k_next = 2'd0;
                    case (cur_phase)
                        wavhp_pkg::PH_RIFF:
                        begin
                            if (!match_new)
                            begin
                                emit        = 1'b1;
                                emit_status = wavhp_pkg::ST_NO_RIFF;
                            end
                            phase_next = wavhp_pkg::PH_RIFFSIZE;
                        end
                        wavhp_pkg::PH_WAVE:
                        begin
                            if (!match_new)
                            begin
                                emit        = 1'b1;
                                emit_status = wavhp_pkg::ST_NO_WAVE;
                            end
                            phase_next = wavhp_pkg::PH_FMT;
                        end
                        wavhp_pkg::PH_FMT:
                        begin
                            if (!match_new)
                            begin
                                emit        = 1'b1;
                                emit_status = wavhp_pkg::ST_NO_FMT;
                            end
                            phase_next = wavhp_pkg::PH_FMTSIZE;
                        end
                        default:
                        begin
                            phase_next = wavhp_pkg::PH_CHUNKSIZE;
                        end
                    endcase
                end
            end
            else if (cur_phase == wavhp_pkg::PH_SKIP)
            begin
                // Skipping chunk body
                skip_next = skip_dec;
                if (skip_dec == 32'd0)
                begin
                    phase_next = wavhp_pkg::PH_CHUNKID;
                end
            end
            else
            begin
                // Little-endian numeric fields
                field_next = field_val;
                if (!field_end)
                begin
                    k_next = cur_k + 2'd1;
                end
                else
                begin
                    k_next = 2'd0;
                    case (cur_phase)
                        wavhp_pkg::PH_RIFFSIZE:
                        begin
                            phase_next = wavhp_pkg::PH_WAVE;
                        end
                        wavhp_pkg::PH_FMTSIZE:
                        begin
                            fmt_len_next = field_val;
                            phase_next   = wavhp_pkg::PH_FORMAT;
                        end
                        wavhp_pkg::PH_FORMAT:
                        begin
                            if (field_val != 32'd1)
                            begin
                                emit        = 1'b1;
                                emit_status = wavhp_pkg::ST_NOT_PCM;
                            end
                            phase_next = wavhp_pkg::PH_CHANS;
                        end
                        wavhp_pkg::PH_CHANS:
                        begin
                            chans_next = field_val[15:0];
                            phase_next = wavhp_pkg::PH_RATE;
                        end
                        wavhp_pkg::PH_RATE:
                        begin
                            rate_next  = field_val;
                            phase_next = wavhp_pkg::PH_BYTERATE;
                        end
                        wavhp_pkg::PH_BYTERATE:
                        begin
                            phase_next = wavhp_pkg::PH_ALIGN;
                        end
                        wavhp_pkg::PH_ALIGN:
                        begin
                            phase_next = wavhp_pkg::PH_BITS;
                        end
                        wavhp_pkg::PH_BITS:
                        begin
                            bits_next = field_val[15:0];
                            if (cur_fmt_len > wavhp_pkg::FMT_STD_LEN)
                            begin
                                skip_next  = pad_skip(cur_fmt_len - wavhp_pkg::FMT_STD_LEN);
                                phase_next = wavhp_pkg::PH_SKIP;
                            end
                            else
                            begin
                                phase_next = wavhp_pkg::PH_CHUNKID;
                            end
                        end
                        wavhp_pkg::PH_CHUNKSIZE:
                        begin
                            if (cur_match)
                            begin
                                // data chunk found: frame count done downstream
                                emit        = 1'b1;
                                emit_status = wavhp_pkg::ST_OK;
                                emit_divide = 1'b1;
                                emit_size   = field_val;
                                emit_offset = cur_pos + 32'd1;
                            end
                            else
                            begin
                                skip_next  = padded;
                                phase_next = (padded == 32'd0) ? wavhp_pkg::PH_CHUNKID
                                                               : wavhp_pkg::PH_SKIP;
                            end
                        end
                        default:
                        begin
                            phase_next = cur_phase;
                        end
                    endcase
                end
            end

            // Stream ended before any result
            if (last_byte && !emit)
            begin
                emit        = 1'b1;
                emit_status = (phase_next inside {wavhp_pkg::PH_SKIP, wavhp_pkg::PH_CHUNKID})
                              ? wavhp_pkg::ST_NO_DATA : wavhp_pkg::ST_TRUNC;
            end

            if (emit)
            begin
                done_next = 1'b1;
            end
        end
    end

    // Result word for the queue
    always_comb
    begin
        job.status   = emit_status;
        job.divide   = emit_divide;
        job.channels = chans_next;
        job.rate     = rate_next;
        job.bits     = bits_next;
        job.size     = emit_size;
        job.offset   = emit_offset;
    end

    assign push = byte_take && emit;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= wavhp_pkg::PH_RIFF;
            k_reg       <= 2'd0;
            field_reg   <= 32'd0;
            fmt_len_reg <= 32'd0;
            skip_reg    <= 32'd0;
            pos_reg     <= 32'd0;
            chans_reg   <= 16'd0;
            rate_reg    <= 32'd0;
            bits_reg    <= 16'd0;
            match_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else if (byte_take)
        begin
            phase_reg   <= phase_next;
            k_reg       <= k_next;
            field_reg   <= field_next;
            fmt_len_reg <= fmt_len_next;
            skip_reg    <= skip_next;
            pos_reg     <= pos_next;
            chans_reg   <= chans_next;
            rate_reg    <= rate_next;
            bits_reg    <= bits_next;
            match_reg   <= match_next;
            done_reg    <= done_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/wavhp_back.sv]
// Result stage: computes the frame count with a bit-serial divider and
// drives the output word. Depends on wavhp_pkg and wav_header_parser_defines.svh.
`default_nettype none
`include "wav_header_parser_defines.svh"

module wavhp_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire wavhp_pkg::job_t q_job,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [2:0]         status,
    output logic [15:0]        channel_count,
    output logic [31:0]        sample_rate,
    output logic [15:0]        sample_bits,
    output logic [31:0]        frame_count,
    output logic [31:0]        data_offset
);

    typedef enum logic [4:0] {
        BK_IDLE = 5'b00001,
        BK_MUL  = 5'b00010,
        BK_CHK  = 5'b00100,
        BK_DIV  = 5'b01000,
        BK_OUT  = 5'b10000
    } bk_state_t;

    bk_state_t       state_reg, state_next;
    logic [4:0]      cnt_reg, cnt_next;
    wavhp_pkg::job_t job_reg, job_next;
    logic [28:0]     frame_reg, frame_next;
    logic [28:0]     rem_reg, rem_next;
    logic [31:0]     quot_reg, quot_next;

    logic [28:0]     frame_prod;
    logic [29:0]     rem_sh;
    logic            rem_ge;

    assign pop       = (state_reg == BK_IDLE) && !q_empty;
    assign out_valid = (state_reg == BK_OUT);

    assign status        = job_reg.status;
    assign channel_count = job_reg.channels;
    assign sample_rate   = job_reg.rate;
    assign sample_bits   = job_reg.bits;
    assign frame_count   = quot_reg;
    assign data_offset   = job_reg.offset;

    // Frame size: channels times whole bytes per sample
    assign frame_prod = {13'd0, job_reg.channels} * {16'd0, job_reg.bits[15:3]};

    // One restoring divide step
    assign rem_sh = {rem_reg, quot_reg[31]};
    assign rem_ge = (rem_sh >= {1'b0, frame_reg});

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        job_next   = job_reg;
        frame_next = frame_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    job_next = q_job;
                    if (q_job.divide)
                    begin
                        quot_next  = q_job.size;
                        state_next = BK_MUL;
                    end
                    else
                    begin
                        quot_next  = 32'd0;
                        state_next = BK_OUT;
                    end
                end
            end
            BK_MUL:
            begin
                frame_next = frame_prod;
                state_next = BK_CHK;
            end
            BK_CHK:
            begin
                if (frame_reg == 29'd0)
                begin
                    job_next.status = wavhp_pkg::ST_ZERO_FRAME;
                    job_next.offset = 32'd0;
                    quot_next       = 32'd0;
                    state_next      = BK_OUT;
                end
                else
                begin
                    rem_next   = 29'd0;
                    cnt_next   = 5'd0;
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                rem_next  = rem_ge ? 29'(rem_sh - {1'b0, frame_reg}) : rem_sh[28:0];
                quot_next = {quot_reg[30:0], rem_ge};
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (out_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Datapath, no reset
    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        frame_reg <= frame_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
    end

    `WAVHP_ASSERT(a_bk_div_nonzero, clk, rst_n, (state_reg == BK_DIV) |-> (frame_reg != 29'd0), "divide by zero frame")
    `WAVHP_ASSERT(a_bk_pop_leaves_idle, clk, rst_n, pop |=> (state_reg != BK_IDLE), "pop without starting work")
    `WAVHP_ASSERT(a_bk_rem_bound, clk, rst_n, (state_reg == BK_DIV) |-> (rem_reg < frame_reg), "remainder not below divisor")

endmodule

`default_nettype wire

[rtl/core/wav_header_parser.sv]
// RIFF/WAVE PCM header parser.
// Input channel (in_valid/in_ready): one file word per cycle: in_byte, with
// first_byte flagging offset 0 of a new file (restarts the parse) and
// last_byte flagging the final word of the stream.
// Output channel (out_valid/out_ready): at most one result per file: status,
// channel_count, sample_rate, sample_bits, frame_count and data_offset.
// Words after a result are consumed and ignored until the next first_byte.
// Throughput: one input word per cycle. in_ready drops only while the
// two-entry result queue between parser and result stage is full.
// Result path: an error result passes through the result queue and then
// the result stage's registers; an ok result also passes the multiply,
// the zero check and the 32-step bit-serial divider for frame_count.
// Reset: parser returns to expecting "RIFF" at stream offset 0, queue and
// output are emptied. A stalled receiver holds the result steady; the
// parser keeps taking words until the queue fills.
// Depends on wavhp_pkg, wavhp_front, wavhp_queue and wavhp_back.
`default_nettype none

module wav_header_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        first_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [15:0]      channel_count,
    output logic [31:0]      sample_rate,
    output logic [15:0]      sample_bits,
    output logic [31:0]      frame_count,
    output logic [31:0]      data_offset
);

    wavhp_pkg::q_ctl_t q_ctl;
    wavhp_pkg::job_t   push_job;
    wavhp_pkg::job_t   pop_job;

    assign in_ready = !q_ctl.full;

    // Front end: header parse
    wavhp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_take  (in_valid && in_ready),
        .in_byte    (in_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .push       (q_ctl.push),
        .job        (push_job)
    );

    // Result queue
    wavhp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_ctl.push),
        .push_job (push_job),
        .pop      (q_ctl.pop),
        .pop_job  (pop_job),
        .full     (q_ctl.full),
        .empty    (q_ctl.empty)
    );

    // Back end: frame count and output word
    wavhp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_ctl.empty),
        .q_job         (pop_job),
        .pop           (q_ctl.pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .channel_count (channel_count),
        .sample_rate   (sample_rate),
        .sample_bits   (sample_bits),
        .frame_count   (frame_count),
        .data_offset   (data_offset)
    );

endmodule

`default_nettype wire
